/* design/nmcl_pkg.sv */
`default_nettype none

package nmcl_pkg;

    // default sizing
    localparam int CELLS_DEF      = 256;
    localparam int COORD_BITS_DEF = 24;

    // fixed field widths
    localparam int SLOT_BITS  = 8;
    localparam int SLOT_RANGE = 1 << SLOT_BITS;
    localparam int LABEL_BITS = 16;
    localparam int COUNT_BITS = 9;

    // item operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOCATE = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

`default_nettype wire

/* design/nmcl_ram.sv */
`default_nettype none

module nmcl_ram #(
    parameter int WIDTH     = 32,
    parameter int DEPTH     = 256,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/navmesh_cell_locator.sv */
`default_nettype none

// navmesh cell locator: keeps a table of CELLS ground triangles (corners A, B, C in the
// x/z plane, signed fixed point, plus a 16-bit label) in one synchronous RAM. An item with
// op = write stores one triangle at slot (modulo CELLS) and produces no result; busy stays
// low. An item with op = locate scans slots 0 .. min(cell_count,CELLS)-1 in order and
// reports the label of the first triangle for which each edge cross product is
// strictly positive, or found = 0 with label 0 when none is. One triangle is read per
// cycle, and an early hit ends the query before the remaining slots are read. The result
// appears for exactly one cycle with done high, the cycle busy falls; the receiver cannot
// stall it and must take it then. Slots must be written before a query scans them.
// cell_count is written through cfg_we / cfg_wdata; the user must do so only while idle,
// as the block itself does not enforce it.
module navmesh_cell_locator #(
    parameter int CELLS      = nmcl_pkg::CELLS_DEF,
    parameter int COORD_BITS = nmcl_pkg::COORD_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [nmcl_pkg::COUNT_BITS-1:0]    cfg_wdata,
    // command side
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               op,
    input  wire logic [nmcl_pkg::SLOT_BITS-1:0]     slot,
    input  wire logic signed [COORD_BITS-1:0]       a_x,
    input  wire logic signed [COORD_BITS-1:0]       a_z,
    input  wire logic signed [COORD_BITS-1:0]       b_x,
    input  wire logic signed [COORD_BITS-1:0]       b_z,
    input  wire logic signed [COORD_BITS-1:0]       c_x,
    input  wire logic signed [COORD_BITS-1:0]       c_z,
    input  wire logic [nmcl_pkg::LABEL_BITS-1:0]    label,
    input  wire logic signed [COORD_BITS-1:0]       point_x,
    input  wire logic signed [COORD_BITS-1:0]       point_z,
    // result side
    output logic                                    done,
    output logic                                    found,
    output logic [nmcl_pkg::LABEL_BITS-1:0]         cell_label
);

    import nmcl_pkg::*;

    // widths
    localparam int CW = COORD_BITS;
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;   // ram address
    localparam int IW = $clog2(CELLS + 1);                  // scan counter, holds CELLS
    localparam int DW = CW + 1;                             // corner differences
    localparam int PW = 2 * DW;                             // products
    localparam int SW = PW + 1;                             // product differences
    localparam int WW = 6 * CW + LABEL_BITS;                // ram word

    // ram word layout
    localparam int OFF_AX  = 0;
    localparam int OFF_AZ  = CW;
    localparam int OFF_BX  = 2 * CW;
    localparam int OFF_BZ  = 3 * CW;
    localparam int OFF_CX  = 4 * CW;
    localparam int OFF_CZ  = 5 * CW;
    localparam int OFF_LBL = 6 * CW;

    // control
    state_t         state_reg, state_next;
    logic [COUNT_BITS-1:0] cell_count_reg;
    logic [IW-1:0]  issue_idx_reg, issue_idx_next;
    logic [IW-1:0]  n_reg, n_next;
    logic           accept_locate;
    logic           accept_write;
    logic           rd_en;
    logic           hit;
    logic           miss;
    logic           finish;

    // valid bits along the scan pipeline
    logic           v_mem_reg, v_d_reg, v_m_reg, v_c_reg;

    // query point
    logic signed [CW-1:0] px_reg, pz_reg;

    // result registers
    logic                  done_reg;
    logic                  found_reg;
    logic [LABEL_BITS-1:0] cell_label_reg;

    // slot to ram address, slot modulo CELLS as a constant table
    logic [AW-1:0] slot_map [SLOT_RANGE];

    for (genvar g = 0; g < SLOT_RANGE; g++)
    begin : g_slot_map
        assign slot_map[g] = AW'(g % CELLS);
    end

    // ram
    logic [WW-1:0] wr_data;
    logic [WW-1:0] rd_data;

    assign wr_data = {label, c_z, c_x, b_z, b_x, a_z, a_x};

    nmcl_ram #(
        .WIDTH     (WW),
        .DEPTH     (CELLS),
        .ADDR_BITS (AW)
    ) u_ram (
        .clk   (clk),
        .we    (accept_write),
        .waddr (slot_map[slot]),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (issue_idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    // corners of the triangle just read
    logic signed [CW-1:0]  ax_m, az_m, bx_m, bz_m, cx_m, cz_m;
    logic [LABEL_BITS-1:0] lbl_m;

    assign ax_m  = $signed(rd_data[OFF_AX +: CW]);
    assign az_m  = $signed(rd_data[OFF_AZ +: CW]);
    assign bx_m  = $signed(rd_data[OFF_BX +: CW]);
    assign bz_m  = $signed(rd_data[OFF_BZ +: CW]);
    assign cx_m  = $signed(rd_data[OFF_CX +: CW]);
    assign cz_m  = $signed(rd_data[OFF_CZ +: CW]);
    assign lbl_m = rd_data[OFF_LBL +: LABEL_BITS];

    // stage d: edge and point vectors, one bit wider than a corner
    logic signed [DW-1:0]  pcx_reg, pcz_reg, bcx_reg, bcz_reg;
    logic signed [DW-1:0]  pbx_reg, pbz_reg, abx_reg, abz_reg;
    logic signed [DW-1:0]  pax_reg, paz_reg, cax_reg, caz_reg;
    logic [LABEL_BITS-1:0] lbl_d_reg;

    always_ff @(posedge clk)
    begin
        pcx_reg   <= DW'(px_reg) - DW'(cx_m);
        pcz_reg   <= DW'(pz_reg) - DW'(cz_m);
        bcx_reg   <= DW'(bx_m) - DW'(cx_m);
        bcz_reg   <= DW'(bz_m) - DW'(cz_m);
        pbx_reg   <= DW'(px_reg) - DW'(bx_m);
        pbz_reg   <= DW'(pz_reg) - DW'(bz_m);
        abx_reg   <= DW'(ax_m) - DW'(bx_m);
        abz_reg   <= DW'(az_m) - DW'(bz_m);
        pax_reg   <= DW'(px_reg) - DW'(ax_m);
        paz_reg   <= DW'(pz_reg) - DW'(az_m);
        cax_reg   <= DW'(cx_m) - DW'(ax_m);
        caz_reg   <= DW'(cz_m) - DW'(az_m);
        lbl_d_reg <= lbl_m;
    end

    // stage m: six products, two per edge test (y of u x v is u.z*v.x - u.x*v.z)
    logic signed [PW-1:0]  m1a_reg, m1b_reg, m2a_reg, m2b_reg, m3a_reg, m3b_reg;
    logic [LABEL_BITS-1:0] lbl_m_reg;

    always_ff @(posedge clk)
    begin
        m1a_reg   <= pcz_reg * bcx_reg;
        m1b_reg   <= pcx_reg * bcz_reg;
        m2a_reg   <= pbz_reg * abx_reg;
        m2b_reg   <= pbx_reg * abz_reg;
        m3a_reg   <= paz_reg * cax_reg;
        m3b_reg   <= pax_reg * caz_reg;
        lbl_m_reg <= lbl_d_reg;
    end

    // stage c: strict sign test of each cross product
    logic signed [SW-1:0]  t1, t2, t3;
    logic                  in_tri;
    logic                  pass_c_reg;
    logic [LABEL_BITS-1:0] lbl_c_reg;

    assign t1 = SW'(m1a_reg) - SW'(m1b_reg);
    assign t2 = SW'(m2a_reg) - SW'(m2b_reg);
    assign t3 = SW'(m3a_reg) - SW'(m3b_reg);

    // zero fails: degenerate triangles and points on an edge never match
    assign in_tri = !t1[SW-1] && (t1 != '0) &&
                    !t2[SW-1] && (t2 != '0) &&
                    !t3[SW-1] && (t3 != '0);

    always_ff @(posedge clk)
    begin
        pass_c_reg <= in_tri;
        lbl_c_reg  <= lbl_m_reg;
    end

    // handshake decode
    assign busy          = (state_reg != ST_IDLE);
    assign accept_write  = start && !busy && (op == OP_WRITE);
    assign accept_locate = start && !busy && (op == OP_LOCATE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        issue_idx_next = issue_idx_reg;
        n_next         = n_reg;
        rd_en          = 1'b0;
        hit            = 1'b0;
        miss           = 1'b0;
        finish         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_locate)
                begin
                    issue_idx_next = '0;
                    // a count above the table size scans the whole table
                    if (32'(cell_count_reg) > CELLS)
                    begin
                        n_next = IW'(CELLS);
                    end
                    else
                    begin
                        n_next = IW'(cell_count_reg);
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // first hit in scan order wins, later slots in flight are dropped
                hit    = v_c_reg && pass_c_reg;
                miss   = (issue_idx_reg == n_reg) && !v_mem_reg && !v_d_reg &&
                         !v_m_reg && !hit;
                finish = hit || miss;
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
                else if (issue_idx_reg != n_reg)
                begin
                    rd_en          = 1'b1;
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cell_count_reg <= '0;
            issue_idx_reg  <= '0;
            n_reg          <= '0;
            v_mem_reg      <= 1'b0;
            v_d_reg        <= 1'b0;
            v_m_reg        <= 1'b0;
            v_c_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_idx_reg <= issue_idx_next;
            n_reg         <= n_next;
            if (cfg_we)
            begin
                cell_count_reg <= cfg_wdata;
            end
            // flush the pipe when a query ends
            v_mem_reg <= rd_en;
            v_d_reg   <= v_mem_reg && !finish;
            v_m_reg   <= v_d_reg && !finish;
            v_c_reg   <= v_m_reg && !finish;
            done_reg  <= finish;
        end
    end

    // query point and result payload
    always_ff @(posedge clk)
    begin
        if (accept_locate)
        begin
            px_reg <= point_x;
            pz_reg <= point_z;
        end
        if (finish)
        begin
            found_reg      <= hit;
            cell_label_reg <= hit ? lbl_c_reg : '0;
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign cell_label = cell_label_reg;

endmodule

`default_nettype wire
